### src/skf_pkg.sv
package skf_pkg;

   localparam int DATA_W      = 32;
   localparam int GAIN_W      = 17;
   localparam int FRAC_W      = 16;
   localparam int DIV_STEPS   = 17;
   localparam int CSR_INDEX_W = 2;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

   localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET     = 32'd655;
   localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RESET = 32'd6554;
   localparam logic [DATA_W-1:0] INITIAL_ESTIMATE_RESET  = 32'd108134;
   localparam logic [DATA_W-1:0] INITIAL_VARIANCE_RESET  = 32'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROCESS_NOISE,
      CSR_MEASUREMENT_NOISE,
      CSR_INITIAL_ESTIMATE,
      CSR_INITIAL_VARIANCE
   } csr_index_type;

   typedef struct packed {
      logic load_in;
      logic predict;
      logic setup;
      logic div_step;
      logic multiply;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

### src/skf_if.sv
interface skf_req_if import skf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] measurement;
   logic                     restart;

   modport source (output valid, output measurement, output restart, input ready);
   modport sink (input valid, input measurement, input restart, output ready);
endinterface

interface skf_rsp_if import skf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] estimate;
   logic        [DATA_W-1:0] variance;
   logic        [GAIN_W-1:0] gain;

   modport source (output valid, output estimate, output variance, output gain,
                   input ready);
   modport sink (input valid, input estimate, input variance, input gain,
                 output ready);
endinterface

### src/skf_ctrl.sv
module skf_ctrl import skf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   localparam int COUNT_W = $clog2(DIV_STEPS);
   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(DIV_STEPS - 1);

   typedef enum logic [2:0] {
      IDLE,
      PRED,
      SETUP,
      DIV,
      MUL,
      UPD
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load_in = 1'b1;
               state_in    = PRED;
            end
         end
         PRED: begin
            cmd.predict = 1'b1;
            state_in    = SETUP;
         end
         SETUP: begin
            cmd.setup = 1'b1;
            count_in  = '0;
            state_in  = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (count_ff == COUNT_LAST) begin
               state_in = MUL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         MUL: begin
            cmd.multiply = 1'b1;
            state_in     = UPD;
         end
         UPD: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      ready_in = (state_in == IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == PRED))
      else $error("accepted beat did not start the update sequence");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result committed while the output register was occupied");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV && count_ff == COUNT_LAST) |=> (state_ff == MUL))
      else $error("divider did not hand over after its last step");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == IDLE))
      else $error("ready raised outside the idle state");

endmodule

### src/skf_dp.sv
module skf_dp import skf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]        csr_write_data,
   input  logic signed [DATA_W-1:0] req_measurement,
   input  logic                     req_restart,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_estimate,
   output logic [DATA_W-1:0]        rsp_variance,
   output logic [GAIN_W-1:0]        rsp_gain
);

   localparam int DIFF_W  = DATA_W + 1;
   localparam int PE_W    = DIFF_W + GAIN_W + 1;
   localparam int PP_W    = DATA_W + GAIN_W;
   localparam int DELTA_W = PE_W - FRAC_W;
   localparam int ESUM_W  = DELTA_W + 1;
   localparam int PN_W    = PP_W - FRAC_W;

   logic [DATA_W-1:0]        q_noise_ff, r_noise_ff, init_var_ff;
   logic signed [DATA_W-1:0] init_est_ff;
   logic signed [DATA_W-1:0] est_ff, est_in;
   logic [DATA_W-1:0]        var_ff, var_in;
   logic                     rsp_valid_ff;

   logic signed [DATA_W-1:0] meas_ff;
   logic [DATA_W-1:0]        ppred_ff;
   logic [DATA_W:0]          den_ff;
   logic                     den_zero_ff;
   logic [DATA_W:0]          rem_ff;
   logic                     nbit_ff;
   logic [GAIN_W-1:0]        quot_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic signed [PE_W-1:0]   prod_e_ff, prod_e_in;
   logic [PP_W-1:0]          prod_p_ff, prod_p_in;
   logic signed [DATA_W-1:0] out_est_ff;
   logic [DATA_W-1:0]        out_var_ff;
   logic [GAIN_W-1:0]        out_gain_ff;

   logic [DATA_W:0]          ppred_sum, den_sum;
   logic [DATA_W-1:0]        ppred_sat;
   logic signed [DIFF_W-1:0] diff_in;
   logic [DATA_W+1:0]        shifted, trial;
   logic                     take;
   logic [DATA_W:0]          rem_in;
   logic [GAIN_W-1:0]        gain_in, one_minus;
   logic signed [DELTA_W-1:0] delta;
   logic signed [ESUM_W-1:0] est_sum;
   logic [PN_W-1:0]          pnew;

   always_comb begin
      ppred_sum = {1'b0, var_ff} + {1'b0, q_noise_ff};
      ppred_sat = ppred_sum[DATA_W] ? '1 : ppred_sum[DATA_W-1:0];
      den_sum   = {1'b0, ppred_ff} + {1'b0, r_noise_ff};
      diff_in   = DIFF_W'(meas_ff) - DIFF_W'(est_ff);

      shifted = {rem_ff, nbit_ff};
      trial   = shifted - {1'b0, den_ff};
      take    = ~trial[DATA_W+1];
      rem_in  = take ? trial[DATA_W:0] : shifted[DATA_W:0];

      gain_in   = den_zero_ff ? '0 : quot_ff;
      one_minus = GAIN_ONE - gain_in;
      prod_e_in = diff_ff * $signed({1'b0, gain_in});
      prod_p_in = PP_W'(one_minus) * PP_W'(ppred_ff);

      delta   = prod_e_ff[PE_W-1:FRAC_W];
      est_sum = ESUM_W'(est_ff) + ESUM_W'(delta);
      if (est_sum > ESUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
         est_in = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (est_sum < -(ESUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) - 1) begin
         est_in = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         est_in = est_sum[DATA_W-1:0];
      end

      pnew   = prod_p_ff[PP_W-1:FRAC_W];
      var_in = pnew[PN_W-1] ? '1 : pnew[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_noise_ff   <= PROCESS_NOISE_RESET;
         r_noise_ff   <= MEASUREMENT_NOISE_RESET;
         init_est_ff  <= INITIAL_ESTIMATE_RESET;
         init_var_ff  <= INITIAL_VARIANCE_RESET;
         est_ff       <= INITIAL_ESTIMATE_RESET;
         var_ff       <= INITIAL_VARIANCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_PROCESS_NOISE:     q_noise_ff  <= csr_write_data;
               CSR_MEASUREMENT_NOISE: r_noise_ff  <= csr_write_data;
               CSR_INITIAL_ESTIMATE:  init_est_ff <= csr_write_data;
               CSR_INITIAL_VARIANCE:  init_var_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (cmd.load_in && req_restart) begin
            est_ff <= init_est_ff;
            var_ff <= init_var_ff;
         end else if (cmd.commit) begin
            est_ff <= est_in;
            var_ff <= var_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         meas_ff <= req_measurement;
      end
      if (cmd.predict) begin
         ppred_ff <= ppred_sat;
      end
      if (cmd.setup) begin
         den_ff      <= den_sum;
         den_zero_ff <= (den_sum == '0);
         rem_ff      <= {2'b00, ppred_ff[DATA_W-1:1]};
         nbit_ff     <= ppred_ff[0];
         diff_ff     <= diff_in;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         nbit_ff <= 1'b0;
         quot_ff <= {quot_ff[GAIN_W-2:0], take};
      end
      if (cmd.multiply) begin
         gain_ff   <= gain_in;
         prod_e_ff <= prod_e_in;
         prod_p_ff <= prod_p_in;
      end
      if (cmd.commit) begin
         out_est_ff  <= est_in;
         out_var_ff  <= var_in;
         out_gain_ff <= gain_ff;
      end
   end

   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = out_est_ff;
   assign rsp_variance = out_var_ff;
   assign rsp_gain     = out_gain_ff;

endmodule

### src/scalar_kalman_filter.sv
// Scalar Kalman filter for a constant-level signal in Q16.16 fixed point. Each accepted
// beat carries one measurement and a restart bit and yields exactly one result beat with
// the new estimate, the new variance and the Q1.16 gain. The restoring divider forms the gain
// one quotient bit per cycle. A new beat is taken only once the filter is idle again. A
// finished result waits in an output register, so the next beat is accepted and worked on
// while it is still pending. The user must write registers only while the filter is idle;
// the block does not enforce it. Writes do not touch the running estimate or variance; only
// reset or a restart beat loads the initial values.
module scalar_kalman_filter import skf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   skf_req_if.sink                req,
   skf_rsp_if.source              rsp,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .cmd       (cmd),
      .status    (status)
   );

   skf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_measurement  (req.measurement),
      .req_restart      (req.restart),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_estimate     (rsp.estimate),
      .rsp_variance     (rsp.variance),
      .rsp_gain         (rsp.gain)
   );

endmodule
